// ===== hw/rtl/fpc_pkg.sv =====
// Shared types, codes and constants of the frustum plane culling block.
package fpc_pkg;

    localparam int unsigned PLANE_COUNT_DEF = 6;
    localparam int unsigned COORD_BITS_DEF  = 32;

    localparam int unsigned ACTION_BITS  = 2;
    localparam int unsigned INDEX_BITS   = 3;
    localparam int unsigned FIELD_BITS   = 32;
    localparam int unsigned RADIUS_BITS  = 31;
    localparam int unsigned Q_SHIFT      = 16;
    localparam int unsigned IDX_EXT_BITS = 5;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_POINT  = 2'd1,
        ACT_SPHERE = 2'd2,
        ACT_BOX    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    typedef struct packed {
        logic valid;
        logic last;
        logic reject;
    } t_dist_res;

endpackage

// ===== hw/rtl/fpc_item_if.sv =====
// Input channel carrying one plane write or one cull test per transaction.
interface fpc_item_if;
    import fpc_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [ACTION_BITS-1:0]       action;
    logic [INDEX_BITS-1:0]        plane_index;
    logic signed [FIELD_BITS-1:0] first_x;
    logic signed [FIELD_BITS-1:0] first_y;
    logic signed [FIELD_BITS-1:0] first_z;
    logic signed [FIELD_BITS-1:0] second_x;
    logic signed [FIELD_BITS-1:0] second_y;
    logic signed [FIELD_BITS-1:0] second_z;
    logic [RADIUS_BITS-1:0]       sphere_radius;
    logic signed [FIELD_BITS-1:0] plane_offset;

    modport source (
        output valid, action, plane_index, first_x, first_y, first_z,
               second_x, second_y, second_z, sphere_radius, plane_offset,
        input  ready
    );

    modport sink (
        input  valid, action, plane_index, first_x, first_y, first_z,
               second_x, second_y, second_z, sphere_radius, plane_offset,
        output ready
    );
endinterface

// ===== hw/rtl/fpc_res_if.sv =====
// Result channel carrying one visibility flag per transaction.
interface fpc_res_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink   (input valid, visible, output ready);
endinterface

// ===== hw/rtl/fpc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fpc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/fpc_dist.sv =====
// Plane distance pipeline: vertex select and products, exact sum, reject compare.
module fpc_dist #(
    parameter int unsigned COORD_BITS = fpc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fpc_pkg::t_tag                i_tag,
    input  logic [4*COORD_BITS-1:0]      i_plane,
    input  logic                         i_plane_vld,
    input  fpc_pkg::t_action             i_action,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_az,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_bz,
    input  logic [fpc_pkg::RADIUS_BITS-1:0] i_radius,
    output fpc_pkg::t_dist_res           o_res
);
    import fpc_pkg::*;

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned PW = 2 * CB;
    localparam int unsigned SW = (PW + 2 > RADIUS_BITS + Q_SHIFT + 2) ?
                                 PW + 2 : RADIUS_BITS + Q_SHIFT + 2;

    logic signed [CB-1:0] nx, ny, nz, nd;
    logic signed [CB-1:0] vx, vy, vz;
    logic signed [PW-1:0] px, py, pz;
    logic                 is_box;
    logic signed [SW-1:0] rad_q;
    logic signed [SW-1:0] thr;
    logic signed [SW-1:0] sum;

    logic signed [PW-1:0] r_px, r_py, r_pz;
    logic signed [CB-1:0] r_d;
    logic signed [SW-1:0] r_thr_a;
    t_tag                 r_tag_a;
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] r_thr_b;
    t_tag                 r_tag_b;

    assign nx = i_plane_vld ? i_plane[4*CB-1:3*CB] : '0;
    assign ny = i_plane_vld ? i_plane[3*CB-1:2*CB] : '0;
    assign nz = i_plane_vld ? i_plane[2*CB-1:CB]   : '0;
    assign nd = i_plane_vld ? i_plane[CB-1:0]      : '0;

    assign is_box = (i_action == ACT_BOX);
    assign vx = (is_box && !nx[CB-1]) ? i_bx : i_ax;
    assign vy = (is_box && !ny[CB-1]) ? i_by : i_ay;
    assign vz = (is_box && !nz[CB-1]) ? i_bz : i_az;

    assign px = nx * vx;
    assign py = ny * vy;
    assign pz = nz * vz;

    assign rad_q = {{(SW-RADIUS_BITS-Q_SHIFT){1'b0}}, i_radius, {Q_SHIFT{1'b0}}};
    assign thr   = (i_action == ACT_SPHERE) ? ('0 - rad_q) : '0;

    always_ff @(posedge i_clk) begin
        r_px    <= px;
        r_py    <= py;
        r_pz    <= pz;
        r_d     <= nd;
        r_thr_a <= thr;
        r_sum   <= sum;
        r_thr_b <= r_thr_a;
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
        end else begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
        end
    end

    assign sum = {{(SW-PW){r_px[PW-1]}}, r_px}
               + {{(SW-PW){r_py[PW-1]}}, r_py}
               + {{(SW-PW){r_pz[PW-1]}}, r_pz}
               + {{(SW-CB-Q_SHIFT){r_d[CB-1]}}, r_d, {Q_SHIFT{1'b0}}};

    assign o_res.valid  = r_tag_b.valid;
    assign o_res.last   = r_tag_b.last;
    assign o_res.reject = r_tag_b.valid && (r_sum < r_thr_b);
endmodule

// ===== hw/rtl/frustum_plane_cull_top.sv =====
// Frustum plane culling block: plane table, scan sequencer and result register.
//
// Input channel i_item takes one transaction per item: a plane write
// (normal in first_x/y/z, offset in plane_offset) or a point, sphere or
// box test. Output channel o_res returns exactly one visible flag per
// item, in order; plane writes always return visible = 1.
// The plane table lives in a small RAM, one row per plane; a test reads
// the rows one per cycle and pushes them through a distance pipeline
// (products, exact sum, compare), so the scan of the RAM read port sets
// the cost of a test.
// A test holds the block through the scan, drain and result states
// before the next item can be accepted; a plane write goes straight
// from acceptance to the result state.
// Items are taken one at a time; a new item is accepted while the previous
// result still waits in the output register. If the receiver stalls, the
// finished result of the next item holds in the sequencer until the
// output register frees.
// Reset marks every plane row as unwritten; such a row reads as an all-zero
// plane that never rejects. No clearing pass is needed.
module frustum_plane_cull_top #(
    parameter int unsigned PLANE_COUNT = fpc_pkg::PLANE_COUNT_DEF,
    parameter int unsigned COORD_BITS  = fpc_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpc_item_if.sink   i_item,
    fpc_res_if.source  o_res
);
    import fpc_pkg::*;

    localparam int unsigned AW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned RW = 4 * CB;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PLANE_COUNT - 1);

    t_state r_state, n_state;

    logic                    in_fire;
    logic                    in_ready;
    logic                    is_write;
    logic [IDX_EXT_BITS-1:0] idx_ext;
    logic                    idx_ok;
    logic                    ram_we;
    logic [AW-1:0]           waddr;
    logic [RW-1:0]           wdata;
    logic [RW-1:0]           rdata;
    logic                    rd_issue;
    logic                    load_out;
    t_dist_res               dres;

    logic [AW-1:0]          r_addr;
    logic [PLANE_COUNT-1:0] r_pvld;
    logic                   r_rd_pvld;
    t_tag                   r_rd_tag;
    logic                   r_reject;
    logic                   r_out_valid;
    logic                   r_visible;
    t_action                r_action;
    logic signed [CB-1:0]   r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic [RADIUS_BITS-1:0] r_radius;

    assign in_fire  = i_item.valid && in_ready;
    assign is_write = (i_item.action == ACT_WRITE);
    assign idx_ext  = {{(IDX_EXT_BITS-INDEX_BITS){1'b0}}, i_item.plane_index};
    assign idx_ok   = idx_ext < IDX_EXT_BITS'(PLANE_COUNT);
    assign ram_we   = in_fire && is_write && idx_ok;
    assign waddr    = idx_ext[AW-1:0];
    assign wdata    = {i_item.first_x[CB-1:0], i_item.first_y[CB-1:0],
                       i_item.first_z[CB-1:0], i_item.plane_offset[CB-1:0]};

    assign i_item.ready = in_ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.visible = r_visible;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = is_write ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (dres.valid && dres.last) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        rd_issue = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE:   in_ready = 1'b1;
            ST_SCAN:   rd_issue = 1'b1;
            ST_DRAIN:  ;
            ST_RESULT: load_out = !r_out_valid || o_res.ready;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= t_action'(i_item.action);
            r_ax     <= i_item.first_x[CB-1:0];
            r_ay     <= i_item.first_y[CB-1:0];
            r_az     <= i_item.first_z[CB-1:0];
            r_bx     <= i_item.second_x[CB-1:0];
            r_by     <= i_item.second_y[CB-1:0];
            r_bz     <= i_item.second_z[CB-1:0];
            r_radius <= i_item.sphere_radius;
        end
        if (load_out) begin
            r_visible <= !r_reject;
        end
        r_rd_pvld <= r_pvld[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_pvld      <= '0;
            r_rd_tag    <= '0;
            r_reject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_rd_tag.valid <= rd_issue;
            r_rd_tag.last  <= rd_issue && (r_addr == LAST_ADDR);
            if (in_fire) begin
                r_addr   <= '0;
                r_reject <= 1'b0;
            end else begin
                if (rd_issue) begin
                    r_addr <= r_addr + AW'(1);
                end
                if (dres.valid && dres.reject) begin
                    r_reject <= 1'b1;
                end
            end
            if (ram_we) begin
                r_pvld[waddr] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    fpc_ram #(
        .WIDTH (RW),
        .DEPTH (PLANE_COUNT)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_issue),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    fpc_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (r_rd_tag),
        .i_plane     (rdata),
        .i_plane_vld (r_rd_pvld),
        .i_action    (r_action),
        .i_ax        (r_ax),
        .i_ay        (r_ay),
        .i_az        (r_az),
        .i_bx        (r_bx),
        .i_by        (r_by),
        .i_bz        (r_bz),
        .i_radius    (r_radius),
        .o_res       (dres)
    );

    a_dist_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dres.valid |-> (r_state == ST_SCAN || r_state == ST_DRAIN))
        else $error("distance result outside a scan");

    a_write_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_write) |=> (r_state == ST_RESULT && !r_reject))
        else $error("plane write did not go straight to a visible result");

    a_last_tag_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_issue && r_addr == LAST_ADDR) |=> (r_rd_tag.last && r_state == ST_DRAIN))
        else $error("last read tag out of step with the scan");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || o_res.ready))
        else $error("result loaded over a pending transaction");
endmodule

// ===== sim/tb_frustum_plane_cull_top.sv =====
// Testbench for frustum_plane_cull_top: bursty plane writes and cull tests checked by a predictor.
module tb_frustum_plane_cull_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpc_pkg::*;

    localparam int PLANES         = PLANE_COUNT_DEF;
    localparam int ONE            = 1 << Q_SHIFT;
    localparam int CMIN           = 32'h8000_0000;
    localparam int CMAX           = 32'h7FFF_FFFF;
    localparam int RMAX           = 32'h7FFF_FFFF;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = PLANES + 10;

    localparam logic signed [65:0] DIST_MAX = 66'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] DIST_MIN = -DIST_MAX - 66'sd1;

    typedef enum int {
        RDY_FREE,
        RDY_COIN,
        RDY_PATTERN
    } t_rdy_mode;

    typedef struct {
        t_action                      op;
        logic [INDEX_BITS-1:0]        idx;
        logic signed [FIELD_BITS-1:0] ax;
        logic signed [FIELD_BITS-1:0] ay;
        logic signed [FIELD_BITS-1:0] az;
        logic signed [FIELD_BITS-1:0] bx;
        logic signed [FIELD_BITS-1:0] by;
        logic signed [FIELD_BITS-1:0] bz;
        logic [RADIUS_BITS-1:0]       radius;
        logic signed [FIELD_BITS-1:0] offset;
    } t_cull_item;

    logic i_clk;
    logic i_rst_n;

    fpc_item_if item_bus ();
    fpc_res_if  res_bus ();

    frustum_plane_cull_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_res   (res_bus)
    );

    t_cull_item pending_q[$];
    bit         visible_q[$];
    t_cull_item drv_item;

    logic signed [FIELD_BITS-1:0] nrm_x[PLANES];
    logic signed [FIELD_BITS-1:0] nrm_y[PLANES];
    logic signed [FIELD_BITS-1:0] nrm_z[PLANES];
    logic signed [FIELD_BITS-1:0] plane_off[PLANES];

    int base_nx[6] = '{0, -1, 0, 1, 0, 0};
    int base_ny[6] = '{-1, 0, 1, 0, 0, 0};
    int base_nz[6] = '{0, 0, 0, 0, 1, -1};

    bit        item_taken;
    bit        exp_vis;
    int        gap_left;
    int        burst_left;
    t_rdy_mode rdy_mode;
    logic [7:0] rdy_pattern;
    int        stall_cycle;
    int        idle_cycles;
    int        fail_count;

    always #1 i_clk = ~i_clk;

    function automatic logic signed [63:0] plane_dist(input int p,
                                                     input logic signed [31:0] px, py, pz);
        logic signed [65:0] wx, wy, wz, wd, ex, ey, ez, sum;
        wx = nrm_x[p];
        wy = nrm_y[p];
        wz = nrm_z[p];
        wd = plane_off[p];
        ex = px;
        ey = py;
        ez = pz;
        sum = wx * ex + wy * ey + wz * ez + (wd <<< Q_SHIFT);
        if (sum > DIST_MAX) sum = DIST_MAX;
        else if (sum < DIST_MIN) sum = DIST_MIN;
        return sum[63:0];
    endfunction

    function automatic bit cull_verdict(input t_cull_item txn);
        bit                  vis;
        logic signed [63:0]  pl_dist;
        logic signed [63:0]  floor_d;
        logic signed [31:0]  vx, vy, vz;
        vis = 1'b1;
        floor_d = -$signed({17'd0, txn.radius, 16'd0});
        if (txn.op == ACT_WRITE) begin
            if (txn.idx < PLANES) begin
                nrm_x[txn.idx] = txn.ax;
                nrm_y[txn.idx] = txn.ay;
                nrm_z[txn.idx] = txn.az;
                plane_off[txn.idx] = txn.offset;
            end
        end else begin
            for (int p = 0; p < PLANES; p++) begin
                vx = txn.ax;
                vy = txn.ay;
                vz = txn.az;
                if (txn.op == ACT_BOX) begin
                    vx = nrm_x[p][31] ? txn.ax : txn.bx;
                    vy = nrm_y[p][31] ? txn.ay : txn.by;
                    vz = nrm_z[p][31] ? txn.az : txn.bz;
                end
                pl_dist = plane_dist(p, vx, vy, vz);
                if (txn.op == ACT_SPHERE ? (pl_dist < floor_d) : (pl_dist < 0)) vis = 1'b0;
            end
        end
        return vis;
    endfunction

    function automatic t_cull_item noise_item();
        t_cull_item t;
        t.op     = t_action'($urandom_range(0, 3));
        t.idx    = INDEX_BITS'($urandom);
        t.ax     = $urandom;
        t.ay     = $urandom;
        t.az     = $urandom;
        t.bx     = $urandom;
        t.by     = $urandom;
        t.bz     = $urandom;
        t.radius = RADIUS_BITS'($urandom);
        t.offset = $urandom;
        return t;
    endfunction

    function automatic int near_coord(input int span);
        return int'($urandom_range(0, 2 * span * ONE)) - span * ONE;
    endfunction

    task automatic add_write(input int idx, input int nx, ny, nz, off);
        t_cull_item t;
        t = noise_item();
        t.op = ACT_WRITE;
        t.idx = INDEX_BITS'(idx);
        t.ax = nx;
        t.ay = ny;
        t.az = nz;
        t.offset = off;
        pending_q.push_back(t);
    endtask

    task automatic add_test(input t_action op, input int ax, ay, az, bx, by, bz, rad);
        t_cull_item t;
        t = noise_item();
        t.op = op;
        t.ax = ax;
        t.ay = ay;
        t.az = az;
        t.bx = bx;
        t.by = by;
        t.bz = bz;
        t.radius = RADIUS_BITS'(rad);
        pending_q.push_back(t);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
        end else if (!item_bus.valid || item_taken) begin
            if (gap_left > 0 || pending_q.size() == 0) begin
                item_bus.valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                drv_item = pending_q.pop_front();
                item_bus.valid         <= 1'b1;
                item_bus.action        <= drv_item.op;
                item_bus.plane_index   <= drv_item.idx;
                item_bus.first_x       <= drv_item.ax;
                item_bus.first_y       <= drv_item.ay;
                item_bus.first_z       <= drv_item.az;
                item_bus.second_x      <= drv_item.bx;
                item_bus.second_y      <= drv_item.by;
                item_bus.second_z      <= drv_item.bz;
                item_bus.sphere_radius <= drv_item.radius;
                item_bus.plane_offset  <= drv_item.offset;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 60);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_cycle == 0) begin
            rdy_mode = t_rdy_mode'($urandom_range(0, 2));
            rdy_pattern = 8'($urandom) | 8'h01;
        end
        stall_cycle = (stall_cycle + 1) % 64;
        case (rdy_mode)
            RDY_FREE: res_bus.ready <= 1'b1;
            RDY_COIN: res_bus.ready <= 1'($urandom_range(0, 1));
            default:  res_bus.ready <= rdy_pattern[stall_cycle % 8];
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_taken <= 1'b0;
            idle_cycles = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (visible_q.size() == 0) begin
                    $error("visible: unexpected transaction, actual %0b", res_bus.visible);
                    fail_count++;
                end else begin
                    exp_vis = visible_q.pop_front();
                    if (res_bus.visible !== exp_vis) begin
                        $error("visible mismatch: expected %0b, actual %0b",
                               exp_vis, res_bus.visible);
                        fail_count++;
                    end
                end
            end
            item_taken <= item_bus.valid && item_bus.ready;
            if (item_bus.valid && item_bus.ready) visible_q.push_back(cull_verdict(drv_item));
            if ((res_bus.valid && res_bus.ready) || (item_bus.valid && item_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_cull_item t;
        int         n_random;
        int         n_tests;
        int         style;
        int         ax, ay, az, bx, by, bz, tmp;
        bit         first_scene;
        t_action    op;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.action = ACT_WRITE;
        item_bus.plane_index = '0;
        item_bus.first_x = '0;
        item_bus.first_y = '0;
        item_bus.first_z = '0;
        item_bus.second_x = '0;
        item_bus.second_y = '0;
        item_bus.second_z = '0;
        item_bus.sphere_radius = '0;
        item_bus.plane_offset = '0;
        res_bus.ready = 1'b0;
        fail_count = 0;
        gap_left = 0;
        burst_left = 0;
        stall_cycle = 0;
        rdy_mode = RDY_FREE;
        rdy_pattern = 8'hFF;
        item_taken = 1'b0;
        idle_cycles = 0;
        for (int p = 0; p < PLANES; p++) begin
            nrm_x[p] = '0;
            nrm_y[p] = '0;
            nrm_z[p] = '0;
            plane_off[p] = '0;
        end

        // planes still at reset never reject
        add_test(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
        add_test(ACT_SPHERE, -5 * ONE, 3 * ONE, 7 * ONE, 0, 0, 0, ONE);
        add_test(ACT_BOX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);

        // axis-aligned cube of half size 10, then ignored writes past the table
        for (int p = 0; p < PLANES; p++)
            add_write(p, base_nx[p] * ONE, base_ny[p] * ONE, base_nz[p] * ONE, 10 * ONE);
        add_write(6, CMIN, CMAX, CMIN, CMAX);
        add_write(7, CMAX, CMIN, CMAX, CMIN);

        add_test(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
        add_test(ACT_POINT, 11 * ONE, 0, 0, 0, 0, 0, 0);
        add_test(ACT_POINT, 10 * ONE, 0, 0, 0, 0, 0, 0);
        add_test(ACT_POINT, 0, 0, -10 * ONE, 0, 0, 0, 0);
        add_test(ACT_SPHERE, 12 * ONE, 0, 0, 0, 0, 0, 2 * ONE);
        add_test(ACT_SPHERE, 12 * ONE, 0, 0, 0, 0, 0, 2 * ONE - 1);
        add_test(ACT_SPHERE, 0, 0, 0, 0, 0, 0, RMAX);
        add_test(ACT_BOX, -5 * ONE, -5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 0);
        add_test(ACT_BOX, 20 * ONE, 20 * ONE, 20 * ONE, 30 * ONE, 30 * ONE, 30 * ONE, 0);
        add_test(ACT_BOX, 30 * ONE, 30 * ONE, 30 * ONE, -30 * ONE, -30 * ONE, -30 * ONE, 0);
        add_test(ACT_BOX, 5 * ONE, 5 * ONE, 5 * ONE, -5 * ONE, -5 * ONE, -5 * ONE, 0);

        // saturate the distance both ways
        add_write(0, CMAX, CMAX, CMAX, CMAX);
        add_test(ACT_POINT, CMIN, CMIN, CMIN, 0, 0, 0, 0);
        add_test(ACT_POINT, CMAX, CMAX, CMAX, 0, 0, 0, 0);
        add_write(1, CMIN, CMIN, CMIN, CMIN);
        add_test(ACT_SPHERE, CMAX, CMAX, CMAX, 0, 0, 0, RMAX);
        add_test(ACT_BOX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);

        n_random = 0;
        first_scene = 1'b1;
        while (n_random < RANDOM_ITEMS) begin
            style = $urandom_range(0, 9);
            for (int p = 0; p < PLANES; p++) begin
                if (first_scene || $urandom_range(0, 9) < 7) begin
                    if ($urandom_range(0, 19) == 0) begin
                        add_write(p, 0, 0, 0, 0);
                    end else if (style < 7) begin
                        add_write(p,
                                  base_nx[p] * ONE + int'($urandom_range(0, ONE / 2)) - ONE / 4,
                                  base_ny[p] * ONE + int'($urandom_range(0, ONE / 2)) - ONE / 4,
                                  base_nz[p] * ONE + int'($urandom_range(0, ONE / 2)) - ONE / 4,
                                  int'($urandom_range(2 * ONE, 20 * ONE)));
                    end else if (style < 9) begin
                        add_write(p, near_coord(1), near_coord(1), near_coord(1), near_coord(20));
                    end else begin
                        t = noise_item();
                        t.op = ACT_WRITE;
                        t.idx = INDEX_BITS'(p);
                        pending_q.push_back(t);
                    end
                    n_random++;
                end
            end
            if ($urandom_range(0, 14) == 0) begin
                t = noise_item();
                t.op = ACT_WRITE;
                t.idx = INDEX_BITS'($urandom_range(PLANES, 7));
                pending_q.push_back(t);
                n_random++;
            end
            n_tests = $urandom_range(5, 40);
            repeat (n_tests) begin
                if ($urandom_range(0, 6) == 0) begin
                    pending_q.push_back(noise_item());
                end else begin
                    op = t_action'($urandom_range(1, 3));
                    ax = near_coord(25);
                    ay = near_coord(25);
                    az = near_coord(25);
                    bx = ax + int'($urandom_range(0, 10 * ONE));
                    by = ay + int'($urandom_range(0, 10 * ONE));
                    bz = az + int'($urandom_range(0, 10 * ONE));
                    if ($urandom_range(0, 9) == 0) begin
                        tmp = ax;
                        ax = bx;
                        bx = tmp;
                    end
                    add_test(op, ax, ay, az, bx, by, bz, int'($urandom_range(0, 8 * ONE)));
                end
                n_random++;
            end
            first_scene = 1'b0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_q.size() != 0 || item_bus.valid || visible_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && visible_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
